/* rtl/json_string_unescape_utf8_unit_assert.svh */
// Assertion shorthands shared by the decoder blocks.
// Both expect clk_i and rst_ni in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/jsu_pkg.sv */
package jsu_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_BODY     = 3'd1,
    PH_ESC      = 3'd2,
    PH_HEX      = 3'd3,
    PH_PAIR_BSL = 3'd4,
    PH_PAIR_U   = 3'd5
  } phase_e;

  // Result status
  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // One input's worth of results: up to four bytes, cnt is count minus one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic            valid;
    status_e         status;
    logic [1:0]      cnt;
  } grp_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

/* rtl/jsu_if.sv */
// Raw byte channel
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Decoded byte channel
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

/* rtl/jsu_decode.sv */
module jsu_decode (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   in_byte_i,
  input  logic         end_i,
  output jsu_pkg::grp_t grp_o
);
  import jsu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [9:0]  high_q, high_d;
  logic        pair_q, pair_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] unit;
  logic [20:0] pair_cp;
  logic [20:0] cp;
  logic [3:0][7:0] enc_bytes;
  logic [1:0]  enc_cnt;
  logic        fail;

  // Hex digit value, either case
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = in_byte_i[3:0];
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_ok  = 1'b1;
      hex_val = in_byte_i[3:0] + 4'd9;
    end
  end

  // Completed code unit and surrogate pair combination
  assign unit    = {acc_q[11:0], hex_val};
  assign pair_cp = 21'h10000 + {1'b0, high_q, unit[9:0]};
  assign cp      = pair_q ? pair_cp : {5'd0, unit};

  // UTF-8 encoding of the code point
  always_comb begin
    enc_bytes = '0;
    if (cp <= 21'h7f) begin
      enc_bytes[0] = cp[7:0];
      enc_cnt      = 2'd0;
    end else if (cp <= 21'h7ff) begin
      enc_bytes[0] = 8'hc0 | {3'd0, cp[10:6]};
      enc_bytes[1] = 8'h80 | {2'd0, cp[5:0]};
      enc_cnt      = 2'd1;
    end else if (cp <= 21'hffff) begin
      enc_bytes[0] = 8'he0 | {4'd0, cp[15:12]};
      enc_bytes[1] = 8'h80 | {2'd0, cp[11:6]};
      enc_bytes[2] = 8'h80 | {2'd0, cp[5:0]};
      enc_cnt      = 2'd2;
    end else begin
      enc_bytes[0] = 8'hf0 | {5'd0, cp[20:18]};
      enc_bytes[1] = 8'h80 | {2'd0, cp[17:12]};
      enc_bytes[2] = 8'h80 | {2'd0, cp[11:6]};
      enc_bytes[3] = 8'h80 | {2'd0, cp[5:0]};
      enc_cnt      = 2'd3;
    end
  end

  // Next state and result group
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    high_d  = high_q;
    pair_d  = pair_q;
    grp_o   = '0;
    grp_o.status = ST_MORE;
    fail    = 1'b0;

    if (end_i) begin
      fail = 1'b1;
    end else begin
      case (phase_q)
        PH_WAIT: begin
          if (in_byte_i != CH_QUOTE) fail = 1'b1;
          else phase_d = PH_BODY;
        end
        PH_BODY: begin
          if (in_byte_i == CH_QUOTE) begin
            phase_d      = PH_WAIT;
            grp_o.status = ST_DONE;
          end else if (in_byte_i < CH_SPACE) begin
            fail = 1'b1;
          end else if (in_byte_i == CH_BSL) begin
            phase_d = PH_ESC;
          end else begin
            grp_o.bytes[0] = in_byte_i;
            grp_o.valid    = 1'b1;
          end
        end
        PH_ESC: begin
          phase_d     = PH_BODY;
          grp_o.valid = 1'b1;
          case (in_byte_i)
            CH_QUOTE, CH_BSL, CH_SLASH: grp_o.bytes[0] = in_byte_i;
            CH_B: grp_o.bytes[0] = 8'h08;
            CH_F: grp_o.bytes[0] = 8'h0c;
            CH_N: grp_o.bytes[0] = 8'h0a;
            CH_R: grp_o.bytes[0] = 8'h0d;
            CH_T: grp_o.bytes[0] = 8'h09;
            CH_U: begin
              grp_o.valid = 1'b0;
              phase_d     = PH_HEX;
              acc_d       = '0;
              dcnt_d      = '0;
              pair_d      = 1'b0;
            end
            default: fail = 1'b1;
          endcase
        end
        PH_HEX: begin
          if (!hex_ok) begin
            fail = 1'b1;
          end else if (dcnt_q != 2'd3) begin
            acc_d  = unit;
            dcnt_d = dcnt_q + 2'd1;
          end else begin
            acc_d  = '0;
            dcnt_d = '0;
            if (pair_q) begin
              if (unit < 16'hdc00 || unit > 16'hdfff) begin
                fail = 1'b1;
              end else begin
                pair_d      = 1'b0;
                high_d      = '0;
                phase_d     = PH_BODY;
                grp_o.bytes = enc_bytes;
                grp_o.cnt   = enc_cnt;
                grp_o.valid = 1'b1;
              end
            end else if (unit >= 16'hd800 && unit <= 16'hdbff) begin
              high_d  = unit[9:0];
              pair_d  = 1'b1;
              phase_d = PH_PAIR_BSL;
            end else if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
              fail = 1'b1;
            end else begin
              phase_d     = PH_BODY;
              grp_o.bytes = enc_bytes;
              grp_o.cnt   = enc_cnt;
              grp_o.valid = 1'b1;
            end
          end
        end
        PH_PAIR_BSL: begin
          if (in_byte_i != CH_BSL) fail = 1'b1;
          else phase_d = PH_PAIR_U;
        end
        PH_PAIR_U: begin
          if (in_byte_i != CH_U) begin
            fail = 1'b1;
          end else begin
            phase_d = PH_HEX;
            acc_d   = '0;
            dcnt_d  = '0;
          end
        end
        default: fail = 1'b1;
      endcase
    end

    // Drop everything on error
    if (fail) begin
      phase_d      = PH_WAIT;
      acc_d        = '0;
      dcnt_d       = '0;
      high_d       = '0;
      pair_d       = 1'b0;
      grp_o        = '0;
      grp_o.status = ST_ERR;
    end else if (grp_o.status == ST_DONE) begin
      acc_d  = '0;
      dcnt_d = '0;
      high_d = '0;
      pair_d = 1'b0;
    end
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      acc_q   <= '0;
      dcnt_q  <= '0;
      high_q  <= '0;
      pair_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      high_q  <= high_d;
      pair_q  <= pair_d;
    end
  end

`include "json_string_unescape_utf8_unit_assert.svh"

  `JSU_ASSERT_NEXT(a_end_resets, accept_i && end_i, phase_q == PH_WAIT)
  `JSU_ASSERT_NOW(a_err_no_byte, grp_o.status == ST_ERR, !grp_o.valid && grp_o.bytes == '0)
  `JSU_ASSERT_NOW(a_digits_in_hex, dcnt_q != 2'd0, phase_q == PH_HEX)
  `JSU_ASSERT_NOW(a_pair_phase, pair_q,
                  phase_q == PH_HEX || phase_q == PH_PAIR_BSL || phase_q == PH_PAIR_U)

endmodule

/* rtl/jsu_serial.sv */
module jsu_serial (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  jsu_pkg::grp_t grp_i,
  output logic          take_o,
  jsu_out_if.source     out_o
);
  import jsu_pkg::*;

  grp_t       grp_q;
  logic       full_q;
  logic [1:0] idx_q;
  logic       pop;
  logic       is_last;

  // Present the current byte of the held group
  assign is_last          = (idx_q == grp_q.cnt);
  assign out_o.valid      = full_q;
  assign out_o.out_byte   = grp_q.bytes[idx_q];
  assign out_o.byte_valid = grp_q.valid;
  assign out_o.status     = grp_q.status;
  assign out_o.last       = is_last;

  assign pop    = full_q && out_o.ready;
  assign take_o = !full_q || (pop && is_last);

  // Hold the group, step through its bytes on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      full_q <= 1'b1;
      idx_q  <= '0;
    end else if (pop && is_last) begin
      full_q <= 1'b0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= grp_i;
  end

`include "json_string_unescape_utf8_unit_assert.svh"

  `JSU_ASSERT_NOW(a_idx_range, full_q, idx_q <= grp_q.cnt)
  `JSU_ASSERT_NEXT(a_idx_step, pop && !is_last && !load_i, full_q && idx_q == $past(idx_q) + 2'd1)
  `JSU_ASSERT_NOW(a_multi_is_data, full_q && grp_q.cnt != 2'd0,
                  grp_q.status == ST_MORE && grp_q.valid)

endmodule

/* rtl/json_string_unescape_utf8_unit.sv */
// Latency: a result appears on out_o in the cycle after its input byte is transferred.
// Throughput: one input byte per cycle while out_o is ready; an escape decoding to N UTF-8
// bytes holds the input while the group register drains them, one byte per cycle while out_o is ready.
// Reset (rst_ni low, asynchronous) clears the parser to waiting for an opening quote
// and empties the group register.
module json_string_unescape_utf8_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  grp_t grp;
  logic take;
  logic accept;

  assign in_i.ready = take;
  assign accept     = in_i.valid && take;

  // Parse one byte per transfer
  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .end_i     (in_i.end_of_input),
    .grp_o     (grp)
  );

  // Serialize result groups
  jsu_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .grp_i  (grp),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

/* dv/json_string_unescape_utf8_unit_tb.sv */
`timescale 1ns / 100ps

module json_string_unescape_utf8_unit_tb;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 45;
  localparam int TAIL_CYCLES  = 16;
  localparam int HOLD_CYCLES  = 80;

  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};

  // One decoded byte as seen on the output channel
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    status_e    st;
    logic       lst;
  } dec_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Decoder shadow state
  phase_e      ph_q;
  logic [15:0] hex_q;
  logic [1:0]  ndig_q;
  logic [9:0]  hi_half_q;
  logic        pair_q;

  dec_item_t expected_utf8 [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int n_mismatch     = 0;
  int cycle_count    = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("json_string_unescape_utf8_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Expected-output computation
  // ---------------------------------------------------------------------------

  task automatic clear_decoder();
    ph_q      = PH_WAIT;
    hex_q     = '0;
    ndig_q    = '0;
    hi_half_q = '0;
    pair_q    = 1'b0;
  endtask

  // Append one predicted byte at the tail of the expected queue
  task automatic queue_expected(dec_item_t it);
    expected_utf8.insert(expected_utf8.size(), it);
  endtask

  task automatic push_one(logic [7:0] b, logic vld, status_e st);
    dec_item_t it;
    it = '{b, vld, st, 1'b1};
    queue_expected(it);
  endtask

  // Error ends the string and drops all decoder state
  task automatic fail_string();
    clear_decoder();
    push_one(8'h00, 1'b0, ST_ERR);
  endtask

  // Expand a code point into 1 to 4 UTF-8 bytes
  task automatic push_utf8(logic [20:0] cp);
    logic [7:0] seq [4];
    int n;
    int i;
    dec_item_t it;
    if (cp <= 21'h7f) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp <= 21'h7ff) begin
      seq[0] = 8'hc0 | {3'd0, cp[10:6]};
      seq[1] = 8'h80 | {2'd0, cp[5:0]};
      n = 2;
    end else if (cp <= 21'hffff) begin
      seq[0] = 8'he0 | {4'd0, cp[15:12]};
      seq[1] = 8'h80 | {2'd0, cp[11:6]};
      seq[2] = 8'h80 | {2'd0, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = 8'hf0 | {5'd0, cp[20:18]};
      seq[1] = 8'h80 | {2'd0, cp[17:12]};
      seq[2] = 8'h80 | {2'd0, cp[11:6]};
      seq[3] = 8'h80 | {2'd0, cp[5:0]};
      n = 4;
    end
    for (i = 0; i < n; i++) begin
      it = '{seq[i], 1'b1, ST_MORE, (i == n - 1)};
      queue_expected(it);
    end
  endtask

  // Hex digit value, -1 when not a digit of either case
  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // Advance the shadow decoder by one transferred byte
  task automatic unescape_byte(logic [7:0] c, logic eoi);
    int d;
    logic [15:0] cu;
    logic [20:0] cp;
    if (eoi) begin
      fail_string();
      return;
    end
    case (ph_q)
      PH_WAIT: begin
        if (c != CH_QUOTE) begin
          fail_string();
        end else begin
          ph_q = PH_BODY;
          push_one(8'h00, 1'b0, ST_MORE);
        end
      end
      PH_BODY: begin
        if (c == CH_QUOTE) begin
          clear_decoder();
          push_one(8'h00, 1'b0, ST_DONE);
        end else if (c < CH_SPACE) begin
          fail_string();
        end else if (c == CH_BSL) begin
          ph_q = PH_ESC;
          push_one(8'h00, 1'b0, ST_MORE);
        end else begin
          push_one(c, 1'b1, ST_MORE);
        end
      end
      PH_ESC: begin
        ph_q = PH_BODY;
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: push_one(c, 1'b1, ST_MORE);
          CH_B: push_one(8'h08, 1'b1, ST_MORE);
          CH_F: push_one(8'h0c, 1'b1, ST_MORE);
          CH_N: push_one(8'h0a, 1'b1, ST_MORE);
          CH_R: push_one(8'h0d, 1'b1, ST_MORE);
          CH_T: push_one(8'h09, 1'b1, ST_MORE);
          CH_U: begin
            ph_q   = PH_HEX;
            hex_q  = '0;
            ndig_q = '0;
            pair_q = 1'b0;
            push_one(8'h00, 1'b0, ST_MORE);
          end
          default: fail_string();
        endcase
      end
      PH_HEX: begin
        d = hex_digit(c);
        if (d < 0) begin
          fail_string();
        end else begin
          hex_q = {hex_q[11:0], d[3:0]};
          if (ndig_q != 2'd3) begin
            ndig_q++;
            push_one(8'h00, 1'b0, ST_MORE);
          end else begin
            cu     = hex_q;
            hex_q  = '0;
            ndig_q = '0;
            if (pair_q) begin
              // second unit must be a low surrogate
              if (cu < 16'hdc00 || cu > 16'hdfff) begin
                fail_string();
              end else begin
                cp = 21'h10000 + {1'b0, hi_half_q, cu[9:0]};
                pair_q    = 1'b0;
                hi_half_q = '0;
                ph_q      = PH_BODY;
                push_utf8(cp);
              end
            end else if (cu >= 16'hd800 && cu <= 16'hdbff) begin
              hi_half_q = cu[9:0];
              pair_q    = 1'b1;
              ph_q      = PH_PAIR_BSL;
              push_one(8'h00, 1'b0, ST_MORE);
            end else if (cu >= 16'hdc00 && cu <= 16'hdfff) begin
              fail_string();
            end else begin
              ph_q = PH_BODY;
              push_utf8({5'b0, cu});
            end
          end
        end
      end
      PH_PAIR_BSL: begin
        if (c != CH_BSL) begin
          fail_string();
        end else begin
          ph_q = PH_PAIR_U;
          push_one(8'h00, 1'b0, ST_MORE);
        end
      end
      PH_PAIR_U: begin
        if (c != CH_U) begin
          fail_string();
        end else begin
          ph_q   = PH_HEX;
          hex_q  = '0;
          ndig_q = '0;
          push_one(8'h00, 1'b0, ST_MORE);
        end
      end
      default: fail_string();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: drive ready, check each transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : out_side
    dec_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_utf8.size() == 0) begin
        $error("unexpected output transfer: out_byte %h status %0d",
               out_ch.out_byte, out_ch.status);
        n_mismatch++;
      end else begin
        want = expected_utf8.pop_front();
        if (out_ch.out_byte !== want.ch) begin
          $error("out_byte: expected %h, got %h", want.ch, out_ch.out_byte);
          n_mismatch++;
        end
        if (out_ch.byte_valid !== want.vld) begin
          $error("byte_valid: expected %b, got %b", want.vld, out_ch.byte_valid);
          n_mismatch++;
        end
        if (out_ch.status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_ch.status);
          n_mismatch++;
        end
        if (out_ch.last !== want.lst) begin
          $error("last: expected %b, got %b", want.lst, out_ch.last);
          n_mismatch++;
        end
      end
    end
    // hold off for a requested stretch, else stall at random
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte, wait for the transfer, then predict its results
  task automatic send_item(logic [7:0] b, logic eoi);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_ch.ready);
    unescape_byte(b, eoi);
    items_sent++;
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, nib - 4'd10};
  endfunction

  task automatic send_hex_digits(logic [15:0] v);
    send_item(hex_char(v[15:12]), 1'b0);
    send_item(hex_char(v[11:8]), 1'b0);
    send_item(hex_char(v[7:4]), 1'b0);
    send_item(hex_char(v[3:0]), 1'b0);
  endtask

  task automatic send_escape_u(logic [15:0] v);
    send_item(CH_BSL, 1'b0);
    send_item(CH_U, 1'b0);
    send_hex_digits(v);
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hff)); while (b == CH_QUOTE || b == CH_BSL);
    return b;
  endfunction

  // Non-surrogate unit from one of the 1-, 2- and 3-byte ranges
  function automatic logic [15:0] rand_bmp_unit();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h0000, 16'h007f));
      1:       return 16'($urandom_range(16'h0080, 16'h07ff));
      2:       return 16'($urandom_range(16'h0800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  // Inject one malformed element
  task automatic send_fault();
    int i;
    int k;
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: send_item(8'($urandom_range(0, 255)), 1'b0);
      1: send_item(8'($urandom_range(0, 255)), 1'b1);
      2: send_escape_u(16'hdc00 + 16'($urandom_range(0, 1023)));
      3: begin
        // high half followed by a random byte or a random second escaped unit
        send_escape_u(16'hd800 + 16'($urandom_range(0, 1023)));
        if ($urandom_range(0, 1)) begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_escape_u(16'($urandom_range(0, 16'hffff)));
        end
      end
      4: begin
        // short run of digits cut by a non-hex byte
        send_item(CH_BSL, 1'b0);
        send_item(CH_U, 1'b0);
        k = $urandom_range(0, 3);
        for (i = 0; i < k; i++) begin
          send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
        end
        do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
        send_item(b, 1'b0);
      end
      default: begin
        send_item(CH_BSL, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  // One literal with random content, mostly well formed
  task automatic send_random_literal();
    int n_elems;
    int fault_at;
    int k;
    logic [15:0] hi;
    if ($urandom_range(0, 19) == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end
    send_item(CH_QUOTE, 1'b0);
    n_elems  = $urandom_range(0, 8);
    fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_elems) : -1;
    for (k = 0; k <= n_elems; k++) begin
      if (k == fault_at) begin
        send_fault();
      end else if (k < n_elems) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_item(rand_plain(), 1'b0);
          4, 5: begin
            send_item(CH_BSL, 1'b0);
            send_item(SIMPLE_ESC[$urandom_range(0, 7)], 1'b0);
          end
          6, 7: send_escape_u(rand_bmp_unit());
          default: begin
            hi = 16'hd800 + 16'($urandom_range(0, 1023));
            send_escape_u(hi);
            send_escape_u(16'hdc00 + 16'($urandom_range(0, 1023)));
          end
        endcase
      end
    end
    send_item(CH_QUOTE, 1'b0);
  endtask

  // Stop offering until every predicted byte has come out
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_utf8.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // missing opening quote, then end of input inside a string
    send_item(8'h41, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(8'hff, 1'b1);
    // byte extremes, a simple escape, a raw control byte
    send_item(CH_QUOTE, 1'b0);
    send_item(8'hff, 1'b0);
    send_text(" \\/");
    send_item(8'h00, 1'b0);
    // bad escape
    send_text("\"\\x");
    // largest pair, then a lone low half
    send_text("\"\\uDBFF\\udfff");
    send_text("\\uDC00");
    pause_until_drained();
  endtask

  task automatic test_random_stream(int idle_pct, int stall_pct, int n_items);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      send_random_literal();
    end
  endtask

  // Hold the output while input keeps coming so the block backs up
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (4) send_random_literal();
    pause_until_drained();
  endtask

  // Let the output empty out between literals
  task automatic test_drain_pause();
    send_idle_pct  = 24;
    recv_stall_pct = 57;
    repeat (3) begin
      send_random_literal();
      pause_until_drained();
    end
  endtask

  task automatic finish_run();
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0 && expected_utf8.size() == 0) begin
      $display("json_string_unescape_utf8_unit regression: pass");
    end else begin
      $display("json_string_unescape_utf8_unit regression: fail");
    end
    $finish;
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    rst_ni             = 1'b0;
    clear_decoder();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_stream(0, 0, PHASE_ITEMS);
    test_random_stream(57, 0, PHASE_ITEMS);
    test_random_stream(0, 57, PHASE_ITEMS);
    test_random_stream(24, 24, PHASE_ITEMS);
    test_output_stall();
    test_drain_pause();
    finish_run();
  end

endmodule
